// ----- hdl/mrlp_pkg.sv -----
package mrlp_pkg;

    localparam int LINE_LIMIT   = 126;
    localparam int LENGTH_WIDTH = 24;
    localparam int CC_W         = $clog2(LINE_LIMIT + 1);
    localparam int ACC_W        = (LENGTH_WIDTH > 10) ? LENGTH_WIDTH : 10;
    localparam int EV_W         = 24;
    localparam int STATUS_W     = 10;

    localparam logic [ACC_W-1:0]        ACC_MAX    = '1;
    localparam logic [LENGTH_WIDTH-1:0] LENGTH_MAX = '1;
    localparam logic [STATUS_W-1:0]     STATUS_MAX = 10'd999;

    localparam logic [CC_W-1:0] STATUS_COL = CC_W'(9);
    localparam logic [CC_W-1:0] LENGTH_COL = CC_W'(16);

    localparam logic [7:0] CHAR_NUL   = 8'h00;
    localparam logic [7:0] CHAR_TAB   = 8'h09;
    localparam logic [7:0] CHAR_LF    = 8'h0A;
    localparam logic [7:0] CHAR_VT    = 8'h0B;
    localparam logic [7:0] CHAR_FF    = 8'h0C;
    localparam logic [7:0] CHAR_CR    = 8'h0D;
    localparam logic [7:0] CHAR_SPACE = 8'h20;
    localparam logic [7:0] CHAR_PLUS  = 8'h2B;
    localparam logic [7:0] CHAR_MINUS = 8'h2D;
    localparam logic [7:0] CHAR_ZERO  = 8'h30;
    localparam logic [7:0] CHAR_NINE  = 8'h39;

    // Keyword slots; the first four are exact-line responses.
    localparam int KW_COUNT   = 6;
    localparam int KW_OK      = 0;
    localparam int KW_ERROR   = 1;
    localparam int KW_NOCARR  = 2;
    localparam int KW_CONNECT = 3;
    localparam int KW_HTTP    = 4;
    localparam int KW_CLEN    = 5;
    localparam int KW_EXACT   = 4;

    localparam logic [3:0] KW_LEN [KW_COUNT] = '{4'd2, 4'd5, 4'd10, 4'd7, 4'd4, 4'd14};
    localparam logic [KW_COUNT-1:0] KW_PREFIX = 6'b110000;
    localparam logic [KW_COUNT-1:0] KW_NOCASE = 6'b100000;

    typedef enum logic [0:0] {
        OP_BYTE  = 1'b0,
        OP_CLEAR = 1'b1
    } t_opcode;

    typedef enum logic [2:0] {
        EV_OK           = 3'd0,
        EV_ERROR        = 3'd1,
        EV_NO_CARRIER   = 3'd2,
        EV_CONNECT      = 3'd3,
        EV_HTTP_STATUS  = 3'd4,
        EV_CONTENT_LEN  = 3'd5,
        EV_PAYLOAD_DONE = 3'd6,
        EV_UNRECOGNIZED = 3'd7
    } t_event_kind;

    typedef enum logic [1:0] {
        MODE_LINE    = 2'd0,
        MODE_SKIP    = 2'd1,
        MODE_PAYLOAD = 2'd2
    } t_mode;

    typedef enum logic [1:0] {
        PH_SPACE = 2'd0,
        PH_POS   = 2'd1,
        PH_NEG   = 2'd2,
        PH_DONE  = 2'd3
    } t_phase;

    typedef struct packed {
        t_opcode    opcode;
        logic [7:0] rx_byte;
    } t_in_item;

    typedef struct packed {
        t_event_kind         event_kind;
        logic [EV_W-1:0]     event_value;
        logic                ok_seen;
        logic                error_seen;
        logic                carrier_lost_seen;
        logic                connect_seen;
        logic [STATUS_W-1:0] status_code;
    } t_out_item;

    function automatic logic [7:0] to_lower(input logic [7:0] c);
        logic [7:0] r;
        r = c;
        if (c >= 8'h41 && c <= 8'h5A) begin
            r = c + 8'd32;
        end
        return r;
    endfunction

    // Keyword text is left-justified in 16 byte slots.
    function automatic logic [127:0] kw_text(input logic [2:0] k);
        logic [127:0] t;
        t = '0;
        case (k)
            3'(KW_OK):      t = {"OK", 112'b0};
            3'(KW_ERROR):   t = {"ERROR", 88'b0};
            3'(KW_NOCARR):  t = {"NO CARRIER", 48'b0};
            3'(KW_CONNECT): t = {"CONNECT", 72'b0};
            3'(KW_HTTP):    t = {"HTTP", 96'b0};
            3'(KW_CLEN):    t = {"Content-length", 16'b0};
            default:        t = '0;
        endcase
        return t;
    endfunction

    function automatic logic kw_char_match(input logic [2:0] k, input logic [3:0] pos,
                                           input logic [7:0] c, input logic nocase);
        logic [127:0] t;
        logic [3:0]   idx;
        logic [7:0]   ch;
        logic [7:0]   a;
        t   = kw_text(k);
        idx = 4'd15 - pos;
        ch  = t[{idx, 3'b000} +: 8];
        a   = c;
        if (nocase) begin
            ch = to_lower(ch);
            a  = to_lower(c);
        end
        return a == ch;
    endfunction

endpackage

// ----- hdl/mrlp_core.sv -----
module mrlp_core
    import mrlp_pkg::*;
(
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  logic      i_advance,
    input  logic      i_suppress,
    input  t_in_item  i_item,
    output logic      o_res_valid,
    output t_out_item o_result
);

    logic [CC_W-1:0]         r_cc, n_cc;
    logic [KW_COUNT-1:0]     r_alive, n_alive;
    logic [ACC_W-1:0]        r_acc, n_acc;
    t_phase                  r_phase, n_phase;
    t_mode                   r_mode, n_mode;
    logic [LENGTH_WIDTH-1:0] r_remaining, n_remaining;
    logic [STATUS_W-1:0]     r_status, n_status;
    logic [LENGTH_WIDTH-1:0] r_length, n_length;
    logic [3:0]              r_flags, n_flags;

    // Per-character update of the line state.
    logic [KW_COUNT-1:0] fc_alive;
    t_phase              fc_phase;
    logic [ACC_W-1:0]    fc_acc;
    logic                col_on;
    logic                num_go;
    logic [7:0]          c;
    logic [ACC_W+3:0]    prod;

    assign c = i_item.rx_byte;

    always_comb begin
        fc_alive = r_alive;
        for (int k = 0; k < KW_COUNT; k++) begin
            if (r_cc < CC_W'(KW_LEN[k])) begin
                if (!kw_char_match(3'(k), r_cc[3:0], c, KW_NOCASE[k])) begin
                    fc_alive[k] = 1'b0;
                end
            end else if (!KW_PREFIX[k]) begin
                fc_alive[k] = 1'b0;
            end
        end

        col_on = 1'b0;
        if (fc_alive[KW_HTTP]) begin
            col_on = (r_cc >= STATUS_COL);
        end else if (fc_alive[KW_CLEN]) begin
            col_on = (r_cc >= LENGTH_COL);
        end

        fc_phase = r_phase;
        fc_acc   = r_acc;
        num_go   = col_on;
        prod     = ({4'b0, r_acc} << 3) + ({4'b0, r_acc} << 1) + (ACC_W + 4)'(c - CHAR_ZERO);
        if (col_on && r_phase == PH_SPACE) begin
            if (c == CHAR_SPACE || c == CHAR_TAB || c == CHAR_VT || c == CHAR_FF) begin
                num_go = 1'b0;
            end else if (c == CHAR_PLUS) begin
                fc_phase = PH_POS;
                num_go   = 1'b0;
            end else if (c == CHAR_MINUS) begin
                fc_phase = PH_NEG;
                num_go   = 1'b0;
            end else begin
                fc_phase = PH_POS;
            end
        end
        if (num_go && fc_phase != PH_DONE) begin
            if (c < CHAR_ZERO || c > CHAR_NINE) begin
                fc_phase = PH_DONE;
            end else if (fc_phase == PH_POS) begin
                // Saturating at the accumulator width gives the same clamped results
                // as a wider count would.
                fc_acc = (prod > (ACC_W + 4)'(ACC_MAX)) ? ACC_MAX : prod[ACC_W-1:0];
            end
        end
    end

    // Line end classification.
    logic [ACC_W-1:0]        v;
    logic [STATUS_W-1:0]     v_status;
    logic [LENGTH_WIDTH-1:0] v_length;
    logic                    exact_hit;
    logic [1:0]              exact_k;

    always_comb begin
        v        = (r_phase == PH_NEG) ? '0 : r_acc;
        v_status = (v > ACC_W'(STATUS_MAX)) ? STATUS_MAX : v[STATUS_W-1:0];
        v_length = (v > ACC_W'(LENGTH_MAX)) ? LENGTH_MAX : v[LENGTH_WIDTH-1:0];
        exact_hit = 1'b0;
        exact_k   = '0;
        for (int k = KW_EXACT - 1; k >= 0; k--) begin
            if (r_alive[k] && r_cc == CC_W'(KW_LEN[k])) begin
                exact_hit = 1'b1;
                exact_k   = 2'(k);
            end
        end
    end

    always_comb begin
        n_cc        = r_cc;
        n_alive     = r_alive;
        n_acc       = r_acc;
        n_phase     = r_phase;
        n_mode      = r_mode;
        n_remaining = r_remaining;
        n_status    = r_status;
        n_length    = r_length;
        n_flags     = r_flags;
        o_res_valid = 1'b0;
        o_result    = '0;
        o_result.event_kind = EV_UNRECOGNIZED;

        if (i_item.opcode == OP_CLEAR) begin
            n_flags  = '0;
            n_status = '0;
        end else begin
            unique case (r_mode)
                MODE_SKIP: begin
                    n_remaining = r_length;
                    n_mode      = (r_length != '0) ? MODE_PAYLOAD : MODE_LINE;
                end
                MODE_PAYLOAD: begin
                    if (r_remaining != '0) begin
                        n_remaining = r_remaining - 1'b1;
                    end
                    if (n_remaining == '0) begin
                        n_status            = '0;
                        n_mode              = MODE_LINE;
                        o_res_valid         = 1'b1;
                        o_result.event_kind = EV_PAYLOAD_DONE;
                    end
                end
                MODE_LINE: begin
                    if (c == CHAR_CR) begin
                        if (!i_suppress) begin
                            if (exact_hit) begin
                                n_flags[exact_k]    = 1'b1;
                                o_res_valid         = 1'b1;
                                o_result.event_kind = t_event_kind'({1'b0, exact_k});
                            end else if (r_alive[KW_HTTP]
                                         && r_cc >= CC_W'(KW_LEN[KW_HTTP])) begin
                                n_status             = v_status;
                                o_res_valid          = 1'b1;
                                o_result.event_kind  = EV_HTTP_STATUS;
                                o_result.event_value = EV_W'(v_status);
                            end else if (r_alive[KW_CLEN]
                                         && r_cc >= CC_W'(KW_LEN[KW_CLEN])) begin
                                if (r_status != '0) begin
                                    n_length = v_length;
                                end
                                o_res_valid          = 1'b1;
                                o_result.event_kind  = EV_CONTENT_LEN;
                                o_result.event_value = EV_W'(v_length);
                            end else if (r_cc == '0) begin
                                if (r_status != '0 && r_length != '0) begin
                                    n_mode = MODE_SKIP;
                                end
                            end else begin
                                o_res_valid         = 1'b1;
                                o_result.event_kind = EV_UNRECOGNIZED;
                            end
                        end
                        n_cc    = '0;
                        n_alive = '1;
                        n_acc   = '0;
                        n_phase = PH_SPACE;
                    end else if (c != CHAR_LF && c != CHAR_NUL
                                 && r_cc < CC_W'(LINE_LIMIT)) begin
                        n_alive = fc_alive;
                        n_phase = fc_phase;
                        n_acc   = fc_acc;
                        n_cc    = r_cc + 1'b1;
                    end
                end
                default: begin
                    n_mode = MODE_LINE;
                end
            endcase
        end

        o_result.ok_seen           = n_flags[KW_OK];
        o_result.error_seen        = n_flags[KW_ERROR];
        o_result.carrier_lost_seen = n_flags[KW_NOCARR];
        o_result.connect_seen      = n_flags[KW_CONNECT];
        o_result.status_code       = n_status;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cc        <= '0;
            r_alive     <= '1;
            r_acc       <= '0;
            r_phase     <= PH_SPACE;
            r_mode      <= MODE_LINE;
            r_remaining <= '0;
            r_status    <= '0;
            r_length    <= '0;
            r_flags     <= '0;
        end else if (i_advance) begin
            r_cc        <= n_cc;
            r_alive     <= n_alive;
            r_acc       <= n_acc;
            r_phase     <= n_phase;
            r_mode      <= n_mode;
            r_remaining <= n_remaining;
            r_status    <= n_status;
            r_length    <= n_length;
            r_flags     <= n_flags;
        end
    end

    a_payload_nonzero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_mode == MODE_PAYLOAD |-> r_remaining != '0)
        else $error("payload mode with no bytes remaining");

    a_status_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_status <= STATUS_MAX)
        else $error("held status above 999");

    a_line_limit: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_cc <= CC_W'(LINE_LIMIT))
        else $error("character count past line limit");

endmodule

// ----- hdl/modem_response_line_parser.sv -----
// Channel   Direction  Valid          Stall          Payload
// in        request    i_in_valid     o_in_stall     i_in_data  (t_in_item)
// out       result     o_out_valid    i_out_stall    o_out_data (t_out_item)
// cfg       write      i_cfg_we       -              i_cfg_data (suppress matching)
//
// A request is classified while it sits in the input register; a new request is accepted
// every cycle unless o_in_stall is high, and its result enters the output register as it retires.
// The result register lets the next request enter while a result waits to be taken.
// A request that produces a result holds in the input register while the output is stalled.
// Reset is synchronous and active low; it clears all parser state and the suppress bit.
module modem_response_line_parser
    import mrlp_pkg::*;
(
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  logic      i_in_valid,
    output logic      o_in_stall,
    input  t_in_item  i_in_data,
    output logic      o_out_valid,
    input  logic      i_out_stall,
    output t_out_item o_out_data,
    input  logic      i_cfg_we,
    input  logic      i_cfg_data
);

    logic      r_in_valid;
    t_in_item  r_in_data;
    logic      r_out_valid;
    t_out_item r_out_data;
    logic      r_suppress;

    logic      advance;
    logic      res_valid;
    t_out_item result;

    mrlp_core u_core (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_advance   (advance),
        .i_suppress  (r_suppress),
        .i_item      (r_in_data),
        .o_res_valid (res_valid),
        .o_result    (result)
    );

    // A request that makes no result can always retire.
    assign advance    = r_in_valid && (!res_valid || !r_out_valid || !i_out_stall);
    assign o_in_stall = r_in_valid && !advance;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (!o_in_stall) begin
            r_in_valid <= i_in_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!o_in_stall && i_in_valid) begin
            r_in_data <= i_in_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (advance && res_valid) begin
            r_out_valid <= 1'b1;
        end else if (!i_out_stall) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (advance && res_valid) begin
            r_out_data <= result;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_suppress <= 1'b0;
        end else if (i_cfg_we) begin
            r_suppress <= i_cfg_data;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out_data;

    a_done_clears_status: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_out_data.event_kind == EV_PAYLOAD_DONE
            |-> o_out_data.status_code == '0)
        else $error("payload done reported with a held status");

    a_ok_flag: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_out_data.event_kind == EV_OK |-> o_out_data.ok_seen)
        else $error("OK reported without its flag");

    a_value_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_out_data.event_kind != EV_HTTP_STATUS
            && o_out_data.event_kind != EV_CONTENT_LEN |-> o_out_data.event_value == '0)
        else $error("nonzero value on an event that carries none");

endmodule

// ----- sim/modem_response_line_parser_tb.sv -----
module modem_response_line_parser_tb;
    timeunit 1ns;
    timeprecision 1ps;
    import mrlp_pkg::*;

    localparam int CYCLE_LIMIT = 500_000;

    logic      i_clk = 1'b0;
    logic      i_rst_n = 1'b0;
    logic      i_in_valid = 1'b0;
    t_in_item  i_in_data = '0;
    logic      i_out_stall = 1'b0;
    logic      i_cfg_we = 1'b0;
    logic      i_cfg_data = 1'b0;
    logic      o_in_stall;
    logic      o_out_valid;
    t_out_item o_out_data;

    modem_response_line_parser dut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .o_in_stall (o_in_stall),
        .i_in_data  (i_in_data),
        .o_out_valid(o_out_valid),
        .i_out_stall(i_out_stall),
        .o_out_data (o_out_data),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_data (i_cfg_data)
    );

    always #6 i_clk = ~i_clk;

    t_in_item    pending_requests[$];
    t_out_item   expected_events[$];
    int unsigned requests_queued = 0;
    int unsigned mismatch_count = 0;
    int unsigned cycle_count = 0;

    // Parser shadow state.
    logic            suppress_on = 1'b0;
    int unsigned     line_len = 0;
    logic [5:0]      kw_live = '1;
    longint unsigned digit_acc = 0;
    t_phase          num_phase = PH_SPACE;
    t_mode           parse_mode_q = MODE_LINE;
    int unsigned     payload_left = 0;
    logic [9:0]      status_held = '0;
    logic [23:0]     length_held = '0;
    logic [3:0]      sticky = '0;

    string kw_word [KW_COUNT] = '{"OK", "ERROR", "NO CARRIER", "CONNECT", "HTTP",
                                  "Content-length"};

    function automatic logic [7:0] fold_case(logic [7:0] c);
        return (c >= "A" && c <= "Z") ? c + 8'd32 : c;
    endfunction

    function automatic void restart_line();
        line_len  = 0;
        kw_live   = '1;
        digit_acc = 0;
        num_phase = PH_SPACE;
    endfunction

    function automatic void reset_parser();
        restart_line();
        suppress_on  = 1'b0;
        parse_mode_q = MODE_LINE;
        payload_left = 0;
        status_held  = '0;
        length_held  = '0;
        sticky       = '0;
    endfunction

    function automatic void post_event(t_event_kind kind, logic [23:0] value);
        t_out_item ev;
        ev.event_kind        = kind;
        ev.event_value       = value;
        ev.ok_seen           = sticky[KW_OK];
        ev.error_seen        = sticky[KW_ERROR];
        ev.carrier_lost_seen = sticky[KW_NOCARR];
        ev.connect_seen      = sticky[KW_CONNECT];
        ev.status_code       = status_held;
        expected_events.push_back(ev);
    endfunction

    // Decimal field: leading blanks, optional sign, then digits until a non-digit.
    function automatic void take_digit(logic [7:0] c);
        if (num_phase == PH_SPACE) begin
            if (c == CHAR_SPACE || c == CHAR_TAB || c == CHAR_VT || c == CHAR_FF) begin
                return;
            end
            if (c == CHAR_PLUS) begin
                num_phase = PH_POS;
                return;
            end
            if (c == CHAR_MINUS) begin
                num_phase = PH_NEG;
                return;
            end
            num_phase = PH_POS;
        end
        if (num_phase == PH_DONE) begin
            return;
        end
        if (c < CHAR_ZERO || c > CHAR_NINE) begin
            num_phase = PH_DONE;
            return;
        end
        if (num_phase == PH_POS) begin
            digit_acc = digit_acc * 10 + (c - CHAR_ZERO);
            if (digit_acc > 64'hFFFF_FFFF) begin
                digit_acc = 64'hFFFF_FFFF;
            end
        end
    endfunction

    function automatic void take_char(logic [7:0] c);
        int unsigned value_col;
        logic [7:0]  want;
        logic [7:0]  have;
        if (line_len >= LINE_LIMIT) begin
            return;
        end
        for (int k = 0; k < KW_COUNT; k++) begin
            if (line_len < kw_word[k].len()) begin
                want = kw_word[k][line_len];
                have = c;
                if (k == KW_CLEN) begin
                    want = fold_case(want);
                    have = fold_case(c);
                end
                if (want != have) begin
                    kw_live[k] = 1'b0;
                end
            end else if (k < KW_HTTP) begin
                kw_live[k] = 1'b0;
            end
        end
        value_col = 'hFFF;
        if (kw_live[KW_HTTP]) begin
            value_col = STATUS_COL;
        end else if (kw_live[KW_CLEN]) begin
            value_col = LENGTH_COL;
        end
        if (line_len >= value_col) begin
            take_digit(c);
        end
        line_len++;
    endfunction

    function automatic void close_line();
        longint unsigned v;
        logic [23:0]     len_val;
        v = (num_phase == PH_NEG) ? 0 : digit_acc;
        for (int k = 0; k < KW_EXACT; k++) begin
            if (kw_live[k] && line_len == kw_word[k].len()) begin
                sticky[k] = 1'b1;
                post_event(t_event_kind'(k), '0);
                return;
            end
        end
        if (kw_live[KW_HTTP] && line_len >= kw_word[KW_HTTP].len()) begin
            status_held = (v > 999) ? STATUS_MAX : v[9:0];
            post_event(EV_HTTP_STATUS, 24'(status_held));
            return;
        end
        if (kw_live[KW_CLEN] && line_len >= kw_word[KW_CLEN].len()) begin
            len_val = (v > 64'hFF_FFFF) ? '1 : v[23:0];
            if (status_held != 0) begin
                length_held = len_val;
            end
            post_event(EV_CONTENT_LEN, len_val);
            return;
        end
        if (line_len == 0) begin
            // A blank line opens the body only when both header values are held.
            if (status_held != 0 && length_held != 0) begin
                parse_mode_q = MODE_SKIP;
            end
            return;
        end
        post_event(EV_UNRECOGNIZED, '0);
    endfunction

    function automatic void advance_parser(t_in_item req);
        logic [7:0] c;
        c = req.rx_byte;
        if (req.opcode == OP_CLEAR) begin
            sticky      = '0;
            status_held = '0;
            return;
        end
        if (parse_mode_q == MODE_SKIP) begin
            payload_left = length_held;
            parse_mode_q = (payload_left != 0) ? MODE_PAYLOAD : MODE_LINE;
            return;
        end
        if (parse_mode_q == MODE_PAYLOAD) begin
            if (payload_left != 0) begin
                payload_left--;
            end
            if (payload_left == 0) begin
                status_held  = '0;
                parse_mode_q = MODE_LINE;
                post_event(EV_PAYLOAD_DONE, '0);
            end
            return;
        end
        if (c == CHAR_CR) begin
            if (!suppress_on) begin
                close_line();
            end
            restart_line();
            return;
        end
        if (c != CHAR_LF && c != CHAR_NUL) begin
            take_char(c);
        end
    endfunction

    // Request driver: bursts of random length separated by random gaps.
    int unsigned burst_left = 0;
    int unsigned gap_left = 0;
    bit          req_taken;

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_in_valid <= 1'b0;
            reset_parser();
            burst_left = 0;
            gap_left   = 0;
        end else begin
            req_taken = i_in_valid && !o_in_stall;
            if (req_taken) begin
                advance_parser(i_in_data);
                void'(pending_requests.pop_front());
                if (burst_left > 0) begin
                    burst_left--;
                end
            end
            if (!i_in_valid || req_taken) begin
                if (burst_left == 0) begin
                    burst_left = $urandom_range(1, 48);
                    gap_left   = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
                end
                if (gap_left > 0) begin
                    gap_left--;
                    i_in_valid <= 1'b0;
                end else if (pending_requests.size() > 0) begin
                    i_in_valid <= 1'b1;
                    i_in_data  <= pending_requests[0];
                end else begin
                    i_in_valid <= 1'b0;
                end
            end
        end
    end

    function automatic void compare_field(string field, int unsigned want, int unsigned got);
        if (want != got) begin
            $display("%0t: %s mismatch, expected %0d, actual %0d", $time, field, want, got);
            mismatch_count++;
        end
    endfunction

    function automatic void check_event(t_out_item got);
        t_out_item want;
        if (expected_events.size() == 0) begin
            $display("%0t: unexpected event, expected none, actual kind %0d value %0d",
                     $time, got.event_kind, got.event_value);
            mismatch_count++;
            return;
        end
        want = expected_events.pop_front();
        compare_field("event_kind", want.event_kind, got.event_kind);
        compare_field("event_value", want.event_value, got.event_value);
        compare_field("ok_seen", want.ok_seen, got.ok_seen);
        compare_field("error_seen", want.error_seen, got.error_seen);
        compare_field("carrier_lost_seen", want.carrier_lost_seen, got.carrier_lost_seen);
        compare_field("connect_seen", want.connect_seen, got.connect_seen);
        compare_field("status_code", want.status_code, got.status_code);
    endfunction

    // Event monitor; the receiver alternates stall runs with free-running stretches.
    int unsigned stall_left = 0;
    bit          stall_on = 1'b0;

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_out_stall <= 1'b0;
            stall_left = 0;
        end else begin
            if (o_out_valid && !i_out_stall) begin
                check_event(o_out_data);
            end
            if (stall_left == 0) begin
                stall_on   = ($urandom_range(0, 2) == 0);
                stall_left = stall_on ? $urandom_range(1, 6) : $urandom_range(1, 40);
            end
            stall_left--;
            i_out_stall <= stall_on;
        end
    end

    always @(posedge i_clk) begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("Mismatches found");
            $finish;
        end
    end

    function automatic void push_byte(logic [7:0] b);
        pending_requests.push_back(t_in_item'{opcode: OP_BYTE, rx_byte: b});
        requests_queued++;
    endfunction

    function automatic void push_clear();
        pending_requests.push_back(t_in_item'{opcode: OP_CLEAR,
                                              rx_byte: 8'($urandom_range(0, 255))});
        requests_queued++;
    endfunction

    function automatic void push_cr();
        push_byte(CHAR_CR);
    endfunction

    // Dropped characters may be sprinkled between the characters of a line.
    function automatic void push_text(string s, bit sprinkle);
        for (int i = 0; i < s.len(); i++) begin
            push_byte(s[i]);
            if (sprinkle && i < s.len() - 1 && $urandom_range(0, 7) == 0) begin
                push_byte($urandom_range(0, 1) ? CHAR_LF : CHAR_NUL);
            end
        end
    endfunction

    function automatic void push_decimal(longint unsigned v);
        push_text($sformatf("%0d", v), 1'b0);
    endfunction

    function automatic void push_clen_key();
        string      key;
        logic [7:0] c;
        key = "Content-length:";
        for (int i = 0; i < key.len(); i++) begin
            c = key[i];
            if (fold_case(c) >= "a" && fold_case(c) <= "z" && $urandom_range(0, 3) == 0) begin
                c = c ^ 8'h20;
            end
            push_byte(c);
        end
    endfunction

    // Lengths are kept small unless allow_big, so that no body runs for millions of bytes.
    function automatic void push_value_field(bit allow_big);
        int unsigned pick;
        repeat ($urandom_range(0, 2)) begin
            pick = $urandom_range(0, 3);
            push_byte(pick == 0 ? CHAR_SPACE : pick == 1 ? CHAR_TAB :
                      pick == 2 ? CHAR_VT : CHAR_FF);
        end
        pick = $urandom_range(0, 5);
        if (pick == 0) begin
            push_byte(CHAR_PLUS);
        end else if (pick == 1) begin
            push_byte(CHAR_MINUS);
        end
        pick = $urandom_range(0, 3);
        if (pick == 1 || (!allow_big && pick != 0)) begin
            push_decimal($urandom_range(0, allow_big ? 999 : 40));
        end else if (pick == 2) begin
            push_decimal($urandom());
        end else if (pick == 3) begin
            repeat ($urandom_range(10, 14)) push_byte(CHAR_NINE);
        end
        if ($urandom_range(0, 2) == 0) begin
            push_text("x7", 1'b0);
        end
    endfunction

    // Well-formed response: status line, length line, blank line, one skipped byte, body.
    function automatic void push_exchange();
        int unsigned body_len;
        push_text("HTTP/1.", 1'b0);
        push_byte(CHAR_ZERO + 8'($urandom_range(0, 1)));
        push_byte(CHAR_SPACE);
        if ($urandom_range(0, 4) != 0) begin
            push_decimal($urandom_range(100, 599));
        end else begin
            push_value_field(1'b1);
        end
        push_cr();
        push_byte(CHAR_LF);
        body_len = ($urandom_range(0, 7) == 0) ? 0 : $urandom_range(1, 24);
        push_clen_key();
        push_byte(CHAR_SPACE);
        push_decimal(body_len);
        push_cr();
        push_byte(CHAR_LF);
        push_cr();
        push_byte(CHAR_LF);
        repeat (body_len) begin
            if ($urandom_range(0, 39) == 0) begin
                push_clear();
            end
            push_byte(8'($urandom_range(0, 255)));
        end
    endfunction

    function automatic void add_random_traffic(int unsigned amount);
        int unsigned stop_at;
        int unsigned pick;
        int unsigned sel;
        string       w;
        stop_at = requests_queued + amount;
        while (requests_queued < stop_at) begin
            pick = $urandom_range(0, 99);
            if (pick < 30) begin
                push_exchange();
            end else if (pick < 48) begin
                push_text(kw_word[$urandom_range(KW_OK, KW_CONNECT)], 1'b1);
                push_cr();
                push_byte(CHAR_LF);
            end else if (pick < 56) begin
                w   = kw_word[$urandom_range(KW_OK, KW_CONNECT)];
                sel = $urandom_range(0, 3);
                if (sel == 0) begin
                    w = w.tolower();
                end else if (sel == 1) begin
                    w = w.substr(0, w.len() - 2);
                end else if (sel == 2) begin
                    w = {w, "X"};
                end else begin
                    w = {"X", w};
                end
                push_text(w, 1'b1);
                push_cr();
            end else if (pick < 66) begin
                sel = $urandom_range(0, 3);
                if (sel == 0) begin
                    push_text("HTTP", 1'b0);
                end else if (sel == 1) begin
                    push_text("HTTP/2", 1'b0);
                end else begin
                    push_text("HTTP/1.1 ", 1'b1);
                    push_value_field(1'b1);
                end
                push_cr();
            end else if (pick < 74) begin
                push_clen_key();
                if ($urandom_range(0, 3) != 0) begin
                    push_byte(CHAR_SPACE);
                    push_value_field(1'b0);
                end
                push_cr();
            end else if (pick < 82) begin
                repeat ($urandom_range(0, 140)) push_byte(8'($urandom_range(0, 255)));
                push_cr();
            end else if (pick < 88) begin
                push_clear();
            end else if (pick < 94) begin
                push_cr();
            end else begin
                repeat ($urandom_range(1, 10)) push_byte(8'($urandom_range(0, 255)));
            end
        end
    endfunction

    // Requests that produce no event can still be in the pipeline after the last event.
    task automatic wait_idle();
        while (pending_requests.size() != 0 || expected_events.size() != 0) begin
            @(negedge i_clk);
        end
        repeat (4) @(negedge i_clk);
    endtask

    task automatic write_suppress(logic value);
        @(posedge i_clk);
        i_cfg_we   <= 1'b1;
        i_cfg_data <= value;
        @(posedge i_clk);
        i_cfg_we    <= 1'b0;
        suppress_on = value;
    endtask

    initial begin
        repeat (4) @(posedge i_clk);
        i_rst_n <= 1'b1;

        push_text("OK", 1'b0);
        push_cr();
        push_byte(CHAR_LF);
        push_text("ERROR", 1'b1);
        push_cr();
        push_text("NO CARRIER", 1'b0);
        push_cr();
        push_byte(CHAR_NUL);
        push_text("CONNECT", 1'b0);
        push_cr();
        push_text("OKAY", 1'b0);
        push_cr();
        push_text("ok", 1'b0);
        push_cr();
        push_clear();

        // Body bytes are taken raw, and a clear in the middle does not stop the body.
        push_text("HTTP/1.1 200", 1'b0);
        push_cr();
        push_text("Content-length: 5", 1'b0);
        push_cr();
        push_cr();
        push_byte(CHAR_LF);
        push_byte(CHAR_CR);
        push_byte(CHAR_NUL);
        push_clear();
        push_byte(8'hFF);
        push_byte(CHAR_LF);
        push_byte(8'h7F);

        push_text("HTTP/1.0 -42", 1'b0);
        push_cr();
        push_text("HTTP/1.0 ", 1'b0);
        push_byte(CHAR_TAB);
        push_byte(CHAR_VT);
        push_byte(CHAR_FF);
        push_text("+1234", 1'b0);
        push_cr();
        push_text("HTTP", 1'b0);
        push_cr();
        push_clear();
        push_text("CONTENT-LENGTH: 77", 1'b0);
        push_cr();
        push_text("Content-length", 1'b0);
        push_cr();
        push_cr();

        push_text("HTTP/1.0 404", 1'b0);
        push_cr();
        push_text("content-length: 99999999999", 1'b0);
        push_cr();
        push_text("Content-Length: 2", 1'b0);
        push_cr();
        push_text("HTTP/1.0 7x9", 1'b0);
        push_cr();
        // Digits that fall past the line limit are ignored.
        push_text("HTTP/1.0 ", 1'b0);
        repeat (115) push_byte(CHAR_SPACE);
        push_text("12345", 1'b0);
        push_cr();
        repeat (200) push_byte("A");
        push_cr();
        push_text("HTTP/1.0 0", 1'b0);
        push_cr();
        push_cr();
        push_text("HTTP/1.0 200", 1'b0);
        push_cr();
        push_text("Content-length: 0", 1'b0);
        push_cr();
        push_cr();
        push_clear();

        // Leave a body running across the switch to suppressed matching.
        push_text("HTTP/1.0 201", 1'b0);
        push_cr();
        push_text("Content-length: 3", 1'b0);
        push_cr();
        push_cr();
        push_byte(CHAR_LF);
        push_byte("O");
        wait_idle();

        write_suppress(1'b1);
        push_byte("K");
        push_byte(CHAR_CR);
        push_text("OK", 1'b0);
        push_cr();
        push_text("HTTP/1.0 200", 1'b0);
        push_cr();
        push_cr();
        add_random_traffic(200);
        wait_idle();

        write_suppress(1'b0);
        add_random_traffic(350);
        wait_idle();

        write_suppress(1'b1);
        add_random_traffic(150);
        wait_idle();

        write_suppress(1'b0);
        add_random_traffic(300);
        wait_idle();
        repeat (8) @(negedge i_clk);

        if (mismatch_count == 0 && expected_events.size() == 0) begin
            $display("No mismatches found");
        end else begin
            $display("Mismatches found");
        end
        $finish;
    end

endmodule
